// File: rtl/coalesced_hash_table_core_defines.svh
// ----------------------------------------------------------------------------
// coalesced hash table assertion macros
// concurrent checks on i_clk, masked while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef COALESCED_HASH_TABLE_CORE_DEFINES_SVH
`define COALESCED_HASH_TABLE_CORE_DEFINES_SVH

`ifndef SYNTH

// property holds at every edge out of reset
`define CHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define CHT_ASSERT(lbl, prop, msg)
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// shared widths, codes and record type of the coalesced hash table
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int SLOTS_DEF   = 11;
    localparam int KEY_W       = 31;
    localparam int NAME_W      = 64;
    localparam int AGE_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int OUT_IDX_W   = 4;
    localparam int OUT_PROBE_W = 4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic MODE_LATE  = 1'b0;
    localparam logic MODE_EARLY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    // record payload held in the record memory
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
        logic [AGE_W-1:0]  age;
    } t_rec;

endpackage

// File: rtl/cht_ram.sv
// ----------------------------------------------------------------------------
// cht_ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cht_pkg::SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/cht_hash.sv
// ----------------------------------------------------------------------------
// cht_hash
// key modulo slot count by reciprocal multiplication, remainder registered
// ----------------------------------------------------------------------------
module cht_hash #(
    parameter int SLOTS = cht_pkg::SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [cht_pkg::KEY_W-1:0] i_key,
    output logic                     o_done,
    output logic [$clog2(SLOTS)-1:0] o_rem
);

    localparam int AW    = $clog2(SLOTS);
    localparam int KW    = cht_pkg::KEY_W;
    localparam int MW    = KW + 1;
    localparam int SHIFT = KW + $clog2(SLOTS);
    localparam int PW    = SHIFT + KW;

    // ceil(2^SHIFT / SLOTS), exact quotient for every key of KW bits
    localparam logic [63:0]   RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
    localparam logic [MW-1:0] RECIP      = RECIP_FULL[MW-1:0];

    logic          r_key_vld;
    logic          r_quo_vld;
    logic          r_done;
    logic [KW-1:0] r_key;
    logic [KW-1:0] r_quo;
    logic [AW-1:0] r_rem;

    logic          busy;
    logic [PW-1:0] prod;
    logic [KW-1:0] back;
    logic [KW-1:0] diff;

    assign busy = r_key_vld || r_quo_vld;
    assign prod = PW'(r_key) * PW'(RECIP);
    assign back = r_quo * KW'(SLOTS);
    assign diff = r_key - back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vld <= 1'b0;
            r_quo_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_key_vld <= i_start && !busy;
            r_quo_vld <= r_key_vld;
            r_done    <= r_quo_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !busy) begin
            r_key <= i_key;
        end
        if (r_key_vld) begin
            r_quo <= prod[SHIFT +: KW];
        end
        // remainder is below SLOTS, so the low bits hold all of it
        if (r_quo_vld) begin
            r_rem <= diff[AW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: rtl/coalesced_hash_table_core.sv
// ----------------------------------------------------------------------------
// coalesced_hash_table_core
// coalesced hash table, late or early insertion, insert and search by key
// ----------------------------------------------------------------------------
// usage:
//   input channel i_in_valid / o_in_stall carries one operation, key, name
//   word and age per transaction; output channel o_out_valid / i_out_stall
//   returns exactly one result per input transaction, in order.
//   i_cfg_wr_en / i_cfg_wr_data set the insertion mode; the user is to write
//   it only while the table is idle, the core itself does not enforce it.
// steps per transaction, from acceptance to result valid:
//   key modulo (reciprocal multiply, then multiply back and subtract),
//   first memory read, chain walk of P probes with P = probe count
//   (1..SLOTS, one slot a cycle), then on a real insert a write state, a
//   link state when a chain link must be updated, and a free-slot rescan
//   over the used bits, then the output stage.
// one transaction is in work at a time; the next is taken once the result
//   has moved to the output register, even while that register is stalled.
// a stalled result holds in the output register; the core then waits with
//   its next result until the register frees.
// reset empties the table at once (used bits in flops), sets late mode and
//   points the free pointer at the top slot; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "coalesced_hash_table_core_defines.svh"

module coalesced_hash_table_core #(
    parameter int SLOTS = cht_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_operation,
    input  logic [cht_pkg::KEY_W-1:0]      i_key,
    input  logic [cht_pkg::NAME_W-1:0]     i_name_word,
    input  logic [cht_pkg::AGE_W-1:0]      i_age,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [cht_pkg::STATUS_W-1:0]   o_status,
    output logic [cht_pkg::OUT_IDX_W-1:0]  o_slot_index,
    output logic [cht_pkg::NAME_W-1:0]     o_found_name,
    output logic [cht_pkg::AGE_W-1:0]      o_found_age,
    output logic [cht_pkg::OUT_PROBE_W-1:0] o_probe_count
);

    localparam int AW  = $clog2(SLOTS);
    localparam int LW  = $clog2(SLOTS + 1);
    localparam int RW  = $bits(cht_pkg::t_rec);
    localparam int SW  = 3;

    localparam logic [LW-1:0] LINK_NULL = LW'(SLOTS);

    localparam logic [SW-1:0] S_IDLE  = 3'd0;
    localparam logic [SW-1:0] S_HASH  = 3'd1;
    localparam logic [SW-1:0] S_WALK  = 3'd2;
    localparam logic [SW-1:0] S_WRITE = 3'd3;
    localparam logic [SW-1:0] S_LINK  = 3'd4;
    localparam logic [SW-1:0] S_SCAN  = 3'd5;
    localparam logic [SW-1:0] S_DONE  = 3'd6;

    logic [SW-1:0]                r_state;
    logic [SW-1:0]                n_state;
    logic                         r_mode;
    logic                         r_op;
    logic [cht_pkg::KEY_W-1:0]    r_key;
    logic [cht_pkg::NAME_W-1:0]   r_name;
    logic [cht_pkg::AGE_W-1:0]    r_age;
    logic [SLOTS-1:0]             r_used;
    logic [AW-1:0]                r_free;
    logic [AW-1:0]                r_home;
    logic [LW-1:0]                r_pos;
    logic [LW-1:0]                r_count;
    logic [LW-1:0]                r_home_link;
    logic [AW-1:0]                r_nf;
    logic [LW-1:0]                r_new_link;
    logic [AW-1:0]                r_link_addr;
    logic                         r_need_link;
    logic [AW-1:0]                r_scan;

    logic [cht_pkg::STATUS_W-1:0] r_res_status;
    logic [LW-1:0]                r_res_slot;
    logic [cht_pkg::NAME_W-1:0]   r_res_name;
    logic [cht_pkg::AGE_W-1:0]    r_res_age;
    logic [LW-1:0]                r_res_probes;

    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [cht_pkg::STATUS_W-1:0] r_out_status;
    logic [cht_pkg::OUT_IDX_W-1:0] r_out_slot;
    logic [cht_pkg::NAME_W-1:0]   r_out_name;
    logic [cht_pkg::AGE_W-1:0]    r_out_age;
    logic [cht_pkg::OUT_PROBE_W-1:0] r_out_probes;

    logic                         accept;
    logic                         out_load;
    logic                         hash_done;
    logic [AW-1:0]                hash_rem;

    logic [AW-1:0]                rd_addr;
    logic [RW-1:0]                rec_rdata;
    cht_pkg::t_rec                rec_rd;
    logic [LW-1:0]                link_rdata;
    logic                         rec_we;
    logic                         link_we;
    logic [AW-1:0]                link_waddr;
    logic [LW-1:0]                link_wdata;

    logic                         used_p;
    logic                         hit;
    logic [LW-1:0]                link_eff;
    logic                         walk_stop;
    logic [LW-1:0]                home_link;
    logic                         home_used;
    logic                         free_ok;
    logic                         ins_go;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    cht_hash #(
        .SLOTS (SLOTS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_key   (i_key),
        .o_done  (hash_done),
        .o_rem   (hash_rem)
    );

    // ---- chain walk decode on the registered read data ----
    assign rec_rd    = cht_pkg::t_rec'(rec_rdata);
    assign used_p    = r_used[r_pos[AW-1:0]];
    assign hit       = used_p && (rec_rd.key == r_key);
    // an empty slot was never linked, so its stored link is not trusted
    assign link_eff  = used_p ? link_rdata : LINK_NULL;
    assign walk_stop = hit || (link_eff >= LINK_NULL) || (r_count == LW'(SLOTS));
    assign home_link = (r_count == LW'(1)) ? link_eff : r_home_link;
    assign home_used = r_used[r_home];
    assign free_ok   = !r_used[r_free];
    // insert that really writes a record
    assign ins_go    = (r_op == cht_pkg::OP_INSERT) && !hit && (!home_used || free_ok);

    // next read follows the link straight from the read data
    always_comb begin
        case (r_state)
            S_HASH:  rd_addr = hash_rem;
            S_WALK:  rd_addr = link_eff[AW-1:0];
            default: rd_addr = r_pos[AW-1:0];
        endcase
    end

    assign rec_we     = (r_state == S_WRITE);
    assign link_we    = (r_state == S_WRITE) || (r_state == S_LINK);
    assign link_waddr = (r_state == S_WRITE) ? r_nf : r_link_addr;
    assign link_wdata = (r_state == S_WRITE) ? r_new_link : LW'(r_nf);

    cht_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (r_nf),
        .i_wdata ({r_key, r_name, r_age}),
        .i_raddr (rd_addr),
        .o_rdata (rec_rdata)
    );

    cht_ram #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (rd_addr),
        .o_rdata (link_rdata)
    );

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (walk_stop) begin
                    n_state = ins_go ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: begin
                n_state = r_need_link ? S_LINK : S_SCAN;
            end
            S_LINK: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (!((r_scan != '0) && r_used[r_scan])) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= cht_pkg::MODE_LATE;
            r_used      <= '0;
            r_free      <= AW'(SLOTS - 1);
            r_count     <= LW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (r_state == S_HASH && hash_done) begin
                r_count <= LW'(1);
            end else if (r_state == S_WALK && !walk_stop) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_WRITE) begin
                r_used[r_nf] <= 1'b1;
            end
            // downward rescan for the highest empty slot
            if (r_state == S_SCAN && !((r_scan != '0) && r_used[r_scan])) begin
                r_free <= r_scan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_operation;
            r_key  <= i_key;
            r_name <= i_name_word;
            r_age  <= i_age;
        end
        if (r_state == S_HASH && hash_done) begin
            r_home <= hash_rem;
            r_pos  <= LW'(hash_rem);
        end
        if (r_state == S_WALK) begin
            if (r_count == LW'(1)) begin
                r_home_link <= link_eff;
            end
            if (!walk_stop) begin
                r_pos <= link_eff;
            end else begin
                r_res_probes <= r_count;
                r_res_slot   <= '0;
                r_res_name   <= '0;
                r_res_age    <= '0;
                r_need_link  <= 1'b0;
                r_new_link   <= LINK_NULL;
                if (r_op == cht_pkg::OP_SEARCH) begin
                    r_res_status <= hit ? cht_pkg::ST_FOUND : cht_pkg::ST_NOT_FOUND;
                    if (hit) begin
                        r_res_slot <= r_pos;
                        r_res_name <= rec_rd.name;
                        r_res_age  <= rec_rd.age;
                    end
                end else if (hit) begin
                    r_res_status <= cht_pkg::ST_DUPLICATE;
                    r_res_slot   <= r_pos;
                end else if (!home_used) begin
                    r_res_status <= cht_pkg::ST_INSERTED;
                    r_res_slot   <= LW'(r_home);
                    r_nf         <= r_home;
                end else if (!free_ok) begin
                    r_res_status <= cht_pkg::ST_FULL;
                end else begin
                    r_res_status <= cht_pkg::ST_INSERTED;
                    r_res_slot   <= LW'(r_free);
                    r_nf         <= r_free;
                    r_need_link  <= 1'b1;
                    if (r_mode == cht_pkg::MODE_EARLY) begin
                        r_new_link  <= home_link;
                        r_link_addr <= r_home;
                    end else begin
                        r_link_addr <= r_pos[AW-1:0];
                    end
                end
            end
        end
        if (r_state == S_WRITE || r_state == S_LINK) begin
            r_scan <= AW'(SLOTS - 1);
        end else if (r_state == S_SCAN) begin
            r_scan <= r_scan - 1'b1;
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= cht_pkg::OUT_IDX_W'(r_res_slot);
            r_out_name   <= r_res_name;
            r_out_age    <= r_res_age;
            r_out_probes <= cht_pkg::OUT_PROBE_W'(r_res_probes);
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot_index  = r_out_slot;
    assign o_found_name  = r_out_name;
    assign o_found_age   = r_out_age;
    assign o_probe_count = r_out_probes;

    // ---- assertions ----
    `CHT_ASSERT(a_free_empty, (r_state == S_IDLE && r_free != '0) |-> !r_used[r_free], "free pointer on used slot")
    `CHT_ASSERT(a_write_empty, (r_state == S_WRITE) |-> !r_used[r_nf], "record written over used slot")
    `CHT_ASSERT(a_probe_range, (r_state == S_WALK) |-> (r_count != '0 && r_count <= LW'(SLOTS)), "probe count out of range")
    `CHT_ASSERT_NEXT(a_out_load, out_load, (o_out_valid && r_state == S_IDLE), "result not loaded")

endmodule

// File: tb/sv/coalesced_hash_table_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coalesced_hash_table_core_tb
// self-checking bench: builds one chain through every slot with late and
// early insertion, hits duplicate, not-found and full cases, then runs random
// insert and search traffic against an in-bench model of the table
// ----------------------------------------------------------------------------
module coalesced_hash_table_core_tb;

    localparam int SLOTS       = cht_pkg::SLOTS_DEF;
    localparam int LINK_NONE   = SLOTS;
    localparam int MAX_REPORTS = 10;
    localparam logic [cht_pkg::KEY_W-1:0] KEY_MAX = {cht_pkg::KEY_W{1'b1}};

    typedef struct packed {
        logic [cht_pkg::STATUS_W-1:0]    status;
        logic [cht_pkg::OUT_IDX_W-1:0]   slot;
        logic [cht_pkg::NAME_W-1:0]      name;
        logic [cht_pkg::AGE_W-1:0]       age;
        logic [cht_pkg::OUT_PROBE_W-1:0] probes;
    } t_outcome;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_wr_en;
    logic                            i_cfg_wr_data;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic                            i_operation;
    logic [cht_pkg::KEY_W-1:0]       i_key;
    logic [cht_pkg::NAME_W-1:0]      i_name_word;
    logic [cht_pkg::AGE_W-1:0]       i_age;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic [cht_pkg::STATUS_W-1:0]    o_status;
    logic [cht_pkg::OUT_IDX_W-1:0]   o_slot_index;
    logic [cht_pkg::NAME_W-1:0]      o_found_name;
    logic [cht_pkg::AGE_W-1:0]       o_found_age;
    logic [cht_pkg::OUT_PROBE_W-1:0] o_probe_count;

    // model of the record store
    bit                         rec_used [SLOTS];
    logic [cht_pkg::KEY_W-1:0]  rec_key  [SLOTS];
    logic [cht_pkg::NAME_W-1:0] rec_name [SLOTS];
    logic [cht_pkg::AGE_W-1:0]  rec_age  [SLOTS];
    int                         rec_link [SLOTS];
    int                         free_slot;
    logic                       insert_mode_q;

    t_outcome pending_outcomes[$];
    int       status_seen [5];
    int       ops_sent;
    int       mode_writes;
    int       deepest_walk;
    int       mismatches;
    int       reports;
    bit       quiet;

    coalesced_hash_table_core #(
        .SLOTS(SLOTS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .i_name_word   (i_name_word),
        .i_age         (i_age),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_found_name  (o_found_name),
        .o_found_age   (o_found_age),
        .o_probe_count (o_probe_count)
    );

    always #2 i_clk = ~i_clk;

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic logic [cht_pkg::NAME_W-1:0] rand_name();
        return {$urandom, $urandom};
    endfunction

    // chain walk from the home slot, then insert or search as the model table does
    function automatic t_outcome apply_table_op(input logic op,
                                                input logic [cht_pkg::KEY_W-1:0] key,
                                                input logic [cht_pkg::NAME_W-1:0] name,
                                                input logic [cht_pkg::AGE_W-1:0] age);
        t_outcome res;
        int       pos;
        int       count;
        int       home;
        int       nf;
        bit       hit;
        res   = '0;
        home  = int'(key % SLOTS);
        pos   = home;
        count = 1;
        while (!(rec_used[pos] && rec_key[pos] == key) && rec_link[pos] < SLOTS
               && count < SLOTS) begin
            pos = rec_link[pos];
            count++;
        end
        hit        = rec_used[pos] && rec_key[pos] == key;
        res.probes = cht_pkg::OUT_PROBE_W'(count);
        if (count > deepest_walk) deepest_walk = count;
        if (op == cht_pkg::OP_SEARCH) begin
            if (hit) begin
                res.status = cht_pkg::ST_FOUND;
                res.slot   = cht_pkg::OUT_IDX_W'(pos);
                res.name   = rec_name[pos];
                res.age    = rec_age[pos];
            end else begin
                res.status = cht_pkg::ST_NOT_FOUND;
            end
        end else if (hit) begin
            res.status = cht_pkg::ST_DUPLICATE;
            res.slot   = cht_pkg::OUT_IDX_W'(pos);
        end else begin
            nf = -1;
            if (!rec_used[home]) begin
                nf = home;
                rec_link[nf] = LINK_NONE;
            end else if (free_slot < SLOTS && !rec_used[free_slot]) begin
                nf = free_slot;
                if (insert_mode_q == cht_pkg::MODE_EARLY) begin
                    rec_link[nf]   = rec_link[home];
                    rec_link[home] = nf;
                end else begin
                    rec_link[pos] = nf;
                    rec_link[nf]  = LINK_NONE;
                end
            end
            if (nf < 0) begin
                res.status = cht_pkg::ST_FULL;
            end else begin
                rec_used[nf] = 1'b1;
                rec_key[nf]  = key;
                rec_name[nf] = name;
                rec_age[nf]  = age;
                // highest empty slot, slot 0 when nothing is left
                free_slot = SLOTS - 1;
                while (free_slot > 0 && rec_used[free_slot]) free_slot--;
                res.status = cht_pkg::ST_INSERTED;
                res.slot   = cht_pkg::OUT_IDX_W'(nf);
            end
        end
        status_seen[res.status]++;
        return res;
    endfunction

    task automatic send_item(input logic op, input logic [cht_pkg::KEY_W-1:0] key,
                             input logic [cht_pkg::NAME_W-1:0] name,
                             input logic [cht_pkg::AGE_W-1:0] age);
        int gap;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        i_name_word <= name;
        i_age       <= age;
        do @(posedge i_clk); while (o_in_stall);
        pending_outcomes.push_back(apply_table_op(op, key, name, age));
        ops_sent++;
    endtask

    task automatic wait_for_outcomes();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_insert_mode(input logic mode);
        wait_for_outcomes();
        repeat (4) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        insert_mode_q = mode;
        mode_writes++;
    endtask

    task automatic test_empty_home();
        write_insert_mode(cht_pkg::MODE_LATE);
        send_item(cht_pkg::OP_SEARCH, KEY_MAX, rand_name(), 8'h5a);
        send_item(cht_pkg::OP_INSERT, '0, '0, '0);
    endtask

    task automatic test_late_chain();
        send_item(cht_pkg::OP_INSERT, 31'd11, rand_name(), 8'd11);
        // home slot 10 is already on the chain of slot 0, so the chains merge
        send_item(cht_pkg::OP_INSERT, 31'd21, rand_name(), 8'd21);
        send_item(cht_pkg::OP_INSERT, '0, rand_name(), 8'd99);
        send_item(cht_pkg::OP_SEARCH, 31'd21, '0, '0);
        send_item(cht_pkg::OP_INSERT, 31'd22, rand_name(), 8'd22);
    endtask

    task automatic test_early_chain();
        write_insert_mode(cht_pkg::MODE_EARLY);
        send_item(cht_pkg::OP_INSERT, 31'd33, rand_name(), 8'd33);
        send_item(cht_pkg::OP_INSERT, 31'd19, rand_name(), 8'd19);
        send_item(cht_pkg::OP_INSERT, 31'd44, rand_name(), 8'd44);
    endtask

    task automatic test_full_table();
        write_insert_mode(cht_pkg::MODE_LATE);
        send_item(cht_pkg::OP_INSERT, 31'd17, rand_name(), 8'd17);
        send_item(cht_pkg::OP_INSERT, 31'd55, '1, '1);
        send_item(cht_pkg::OP_INSERT, 31'd3, rand_name(), 8'd3);
        // last free slot taken, chain now runs through all slots
        send_item(cht_pkg::OP_INSERT, 31'd66, rand_name(), 8'd66);
        send_item(cht_pkg::OP_SEARCH, 31'd66, '0, '0);
        send_item(cht_pkg::OP_SEARCH, 31'd77, '0, '0);
        send_item(cht_pkg::OP_INSERT, KEY_MAX, '1, '1);
        send_item(cht_pkg::OP_SEARCH, 31'd55, '0, '0);
        write_insert_mode(cht_pkg::MODE_EARLY);
        send_item(cht_pkg::OP_INSERT, 31'd88, rand_name(), 8'd88);
        send_item(cht_pkg::OP_SEARCH, '0, '1, '1);
    endtask

    task automatic test_random_traffic(input int count);
        int                        i;
        int                        pick;
        int                        s;
        logic                      op;
        logic [cht_pkg::KEY_W-1:0] key;
        for (i = 0; i < count; i++) begin
            if (i % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
            if (i == count / 2) write_insert_mode(~insert_mode_q);
            op   = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            s    = $urandom_range(0, SLOTS - 1);
            // mostly keys that are stored, so searches hit and inserts collide
            if (pick < 60 && rec_used[s]) key = rec_key[s];
            else if (pick < 80) key = cht_pkg::KEY_W'($urandom_range(0, 8 * SLOTS));
            else key = cht_pkg::KEY_W'($urandom);
            send_item(op, key, rand_name(), cht_pkg::AGE_W'($urandom));
        end
        quiet = 1'b0;
    endtask

    initial begin : result_sink
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = draw_wait();
            @(negedge i_clk);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_outcome want;
        t_outcome got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_status, o_slot_index, o_found_name, o_found_age, o_probe_count};
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("unexpected result: status %0d slot %0d probes %0d",
                             got.status, got.slot, got.probes);
                end
            end else begin
                want = pending_outcomes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (reports < MAX_REPORTS) begin
                        reports++;
                        $display("mismatch (exp/act): status %0d/%0d slot %0d/%0d",
                                 want.status, got.status, want.slot, got.slot);
                        $display("  name %h/%h age %0d/%0d probes %0d/%0d",
                                 want.name, got.name, want.age, got.age,
                                 want.probes, got.probes);
                    end
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("coalesced_hash_table_core_tb failed");
        $finish;
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_in_valid    = 1'b0;
        i_operation   = cht_pkg::OP_INSERT;
        i_key         = '0;
        i_name_word   = '0;
        i_age         = '0;
        i_out_stall   = 1'b0;
        quiet         = 1'b0;
        insert_mode_q = cht_pkg::MODE_LATE;
        free_slot     = SLOTS - 1;
        for (int k = 0; k < SLOTS; k++) begin
            rec_used[k] = 1'b0;
            rec_key[k]  = '0;
            rec_name[k] = '0;
            rec_age[k]  = '0;
            rec_link[k] = LINK_NONE;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_home();
        test_late_chain();
        test_early_chain();
        test_full_table();
        test_random_traffic(1880);

        wait_for_outcomes();
        repeat (4 * SLOTS + 30) @(posedge i_clk);

        $display("%0d transactions: %0d inserted, %0d duplicate, %0d found,",
                 ops_sent, status_seen[cht_pkg::ST_INSERTED],
                 status_seen[cht_pkg::ST_DUPLICATE], status_seen[cht_pkg::ST_FOUND]);
        $display("%0d missing, %0d full, %0d insert mode writes, longest walk %0d probes",
                 status_seen[cht_pkg::ST_NOT_FOUND], status_seen[cht_pkg::ST_FULL],
                 mode_writes, deepest_walk);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("coalesced_hash_table_core_tb passed");
        end else begin
            $display("coalesced_hash_table_core_tb failed");
        end
        $finish;
    end

endmodule
